@@ src/md5sh_pkg.sv @@
// Package for the MD5 stream hasher: commands, controller states and round tables.
// No dependencies.
package md5sh_pkg;

  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_FINISH  = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COMP,
    ST_FOLD,
    ST_PAD,
    ST_EMIT,
    ST_ERR
  } state_t;

  typedef enum logic [1:0] {
    BSEL_DATA = 2'd0,
    BSEL_PAD  = 2'd1,
    BSEL_ZERO = 2'd2,
    BSEL_LEN  = 2'd3
  } bsel_t;

  typedef struct packed {
    logic       init;
    logic       buf_we;
    bsel_t      bsel;
    logic [5:0] buf_addr;
    logic       count_inc;
    logic       round_start;
    logic       round_en;
    logic [5:0] round;
    logic       fold;
    logic [1:0] out_sel;
  } md5sh_cmd_t;

  localparam logic [31:0] IV [4] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};

  localparam logic [31:0] K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [5:0] g;
    begin
      case (i[5:4])
        2'd0: g = i;
        2'd1: g = {i[3:0], 2'b00} + i + 6'd1;
        2'd2: g = {i[4:0], 1'b0} + i + 6'd5;
        default: g = {i[2:0], 3'b000} - i;
      endcase
      msg_index = g[3:0];
    end
  endfunction

endpackage

@@ src/md5_stream_hasher.sv @@
// MD5 stream hasher top level: controller plus datapath.
// Depends on md5sh_pkg, md5sh_ctrl and md5sh_datapath.
// A user sees one byte per transaction; the 64th byte of a block starts a compression
// that holds the input through one buffer read, 64 rounds in one shared round unit and
// the fold. Finish writes the pad bytes one per cycle, compresses one or two blocks,
// then returns four digest transactions, word A first; a repeated finish returns the
// digest at once.
module md5_stream_hasher import md5sh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last,
  output logic        error
);
  md5sh_cmd_t ctl;
  logic [5:0] fill;
  logic [31:0] dword;

  md5sh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cmd(cmd), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .word_index(word_index),
    .last(last), .error(error), .fill(fill), .ctl(ctl)
  );

  md5sh_datapath u_dp (
    .clk(clk), .ctl(ctl), .data_byte(data_byte), .fill(fill), .digest_word(dword)
  );

  assign digest_word = error ? 32'd0 : dword;
endmodule

@@ src/md5sh_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module md5sh_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/md5sh_datapath.sv @@
// MD5 datapath: byte buffer as four byte-lane RAMs, round unit, chaining words, byte count.
// Depends on md5sh_pkg and md5sh_ram.
module md5sh_datapath import md5sh_pkg::*; (
  input  logic        clk,
  input  md5sh_cmd_t  ctl,
  input  logic [7:0]  data_byte,
  output logic [5:0]  fill,
  output logic [31:0] digest_word
);
  logic [31:0] cv [4];
  logic [31:0] a, b, c, d;
  logic [63:0] byte_count;
  logic [63:0] bits;
  logic [7:0]  wbyte;
  logic [3:0]  lane_we;
  logic [31:0] mword;
  logic [3:0]  raddr;
  logic [31:0] f, fsum, rot;
  logic [5:0]  rnd;
  logic [4:0]  s;

  assign fill = byte_count[5:0];
  assign bits = {byte_count[60:0], 3'b000};

  always_comb begin
    case (ctl.bsel)
      BSEL_DATA: wbyte = data_byte;
      BSEL_PAD:  wbyte = 8'h80;
      BSEL_ZERO: wbyte = 8'h00;
      default:   wbyte = bits[{ctl.buf_addr[2:0], 3'b000} +: 8];
    endcase
  end

  assign raddr = msg_index(ctl.round);

  genvar ln;
  for (ln = 0; ln < 4; ln++) begin : g_lane
    assign lane_we[ln] = ctl.buf_we && (ctl.buf_addr[1:0] == 2'(ln));
    md5sh_ram #(.Width(8), .Depth(16)) u_ram (
      .clk(clk), .we(lane_we[ln]), .waddr(ctl.buf_addr[5:2]), .wdata(wbyte),
      .raddr(raddr), .rdata(mword[ln*8 +: 8])
    );
  end

  // The round index is registered, so it lags the read address like the registered RAM read.
  always_ff @(posedge clk) begin
    rnd <= ctl.round;
  end

  always_comb begin
    case (rnd[5:4])
      2'd0: f = d ^ (b & (c ^ d));
      2'd1: f = c ^ (d & (b ^ c));
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    s = ROT[{rnd[5:4], rnd[1:0]}];
    fsum = f + a + K[rnd] + mword;
    rot = (fsum << s) | (fsum >> (6'd32 - {1'b0, s}));
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      for (int i = 0; i < 4; i++) cv[i] <= IV[i];
      byte_count <= '0;
    end else begin
      if (ctl.count_inc) byte_count <= byte_count + 64'd1;
      if (ctl.fold) begin
        cv[0] <= cv[0] + a;
        cv[1] <= cv[1] + b;
        cv[2] <= cv[2] + c;
        cv[3] <= cv[3] + d;
      end
    end
    if (ctl.round_start) begin
      a <= cv[0]; b <= cv[1]; c <= cv[2]; d <= cv[3];
    end else if (ctl.round_en) begin
      a <= d; d <= c; c <= b; b <= b + rot;
    end
  end

  assign digest_word = cv[ctl.out_sel];
endmodule

@@ src/md5sh_ctrl.sv @@
// MD5 controller: accepts commands, sequences padding, rounds and digest output.
// Depends on md5sh_pkg.
module md5sh_ctrl import md5sh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] cmd,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] word_index,
  output logic       last,
  output logic       error,
  input  logic [5:0] fill,
  output md5sh_cmd_t ctl
);
  state_t state, state_next;
  logic [6:0] cnt, cnt_next;
  logic [5:0] pad_pos, pad_pos_next;
  logic done, done_next;
  logic pad_final, pad_final_next;
  logic padding, padding_next;
  logic second, second_next;
  logic [1:0] widx, widx_next;
  logic padding_last;
  logic in_fire, out_fire;

  assign in_fire = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT) || (state == ST_ERR);
  assign word_index = (state == ST_ERR) ? 2'd0 : widx;
  assign last = (state == ST_ERR) || (widx == 2'd3);
  assign error = (state == ST_ERR);

  // A second padding block exists when the pad byte did not leave room for the length.
  assign padding_last = second || (fill < 6'd56);

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    pad_pos_next = pad_pos;
    done_next = done;
    pad_final_next = pad_final;
    padding_next = padding;
    second_next = second;
    widx_next = widx;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            CMD_APPEND: begin
              if (done) begin
                state_next = ST_ERR;
              end else if (fill == 6'd63) begin
                state_next = ST_COMP;
                cnt_next = '0;
                pad_final_next = 1'b0;
              end
            end
            CMD_FINISH: begin
              widx_next = '0;
              if (done) begin
                state_next = ST_EMIT;
              end else begin
                state_next = ST_PAD;
                pad_pos_next = fill;
                padding_next = 1'b1;
                second_next = 1'b0;
                pad_final_next = 1'b0;
              end
            end
            CMD_RESTART: done_next = 1'b0;
            default: ;
          endcase
        end
      end
      ST_PAD: begin
        pad_pos_next = pad_pos + 6'd1;
        if (pad_pos == 6'd63) begin
          state_next = ST_COMP;
          cnt_next = '0;
          pad_final_next = padding_last;
        end
      end
      ST_COMP: begin
        cnt_next = cnt + 7'd1;
        if (cnt == 7'd64) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        if (pad_final) begin
          state_next = ST_EMIT;
          done_next = 1'b1;
          padding_next = 1'b0;
        end else if (padding) begin
          state_next = ST_PAD;
          pad_pos_next = 6'd0;
          second_next = 1'b1;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          widx_next = widx + 2'd1;
          if (widx == 2'd3) state_next = ST_IDLE;
        end
      end
      ST_ERR: if (out_fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      pad_pos <= '0;
      done <= 1'b0;
      pad_final <= 1'b0;
      padding <= 1'b0;
      second <= 1'b0;
      widx <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      pad_pos <= pad_pos_next;
      done <= done_next;
      pad_final <= pad_final_next;
      padding <= padding_next;
      second <= second_next;
      widx <= widx_next;
    end
  end

  always_comb begin
    ctl = '0;
    ctl.out_sel = widx;
    case (state)
      ST_IDLE: begin
        if (in_fire && cmd == CMD_APPEND && !done) begin
          ctl.buf_we = 1'b1;
          ctl.bsel = BSEL_DATA;
          ctl.buf_addr = fill;
          ctl.count_inc = 1'b1;
        end
        if (in_fire && cmd == CMD_RESTART) ctl.init = 1'b1;
        ctl.round_start = 1'b1;
      end
      ST_PAD: begin
        ctl.buf_we = 1'b1;
        ctl.buf_addr = pad_pos;
        if (!second && pad_pos == fill) ctl.bsel = BSEL_PAD;
        else if (pad_pos >= 6'd56 && padding_last) ctl.bsel = BSEL_LEN;
        else ctl.bsel = BSEL_ZERO;
        ctl.round_start = 1'b1;
      end
      ST_COMP: begin
        ctl.round = cnt[5:0];
        ctl.round_en = (cnt != 7'd0);
      end
      ST_FOLD: ctl.fold = 1'b1;
      default: ;
    endcase
    if (rst) ctl.init = 1'b1;
  end

  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("input and output open together");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMP && cnt == 7'd64) |=> state == ST_FOLD)
    else $error("round count did not end in fold");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_fire && widx == 2'd3) |=> state == ST_IDLE && done)
    else $error("digest output did not close");
endmodule

@@ verif/md5_stream_hasher_tb.sv @@
// Testbench for md5_stream_hasher: byte streams with finish, restart and error
// commands, checked against an in-bench MD5 predictor. Depends on md5sh_pkg.
module md5_stream_hasher_tb;
  import md5sh_pkg::*;

  typedef struct packed {
    cmd_t       op;
    logic [7:0] data;
  } hash_op_t;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        last;
    logic        err;
  } digest_beat_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  cmd;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last;
  logic        error;

  hash_op_t     pending_ops[$];
  digest_beat_t expected_beats[$];
  int           mismatches;
  int           in_wait;
  int           out_wait;
  bit           in_accepted;
  bit           out_accepted;
  bit           stim_done;
  bit           hold_sender;
  int           digests_seen;
  int           errors_seen;

  // Predictor state.
  logic [31:0] chain[4];
  logic [7:0]  blk[64];
  int          fill;
  logic [63:0] nbytes;
  bit          finished;

  md5_stream_hasher u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
    .data_byte(data_byte), .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .word_index(word_index), .last(last), .error(error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic md5_compress();
    logic [31:0] m[16];
    logic [31:0] a, b, c, d, f, t;
    int g;
    int grp;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 16; i++)
      m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    for (int i = 0; i < 64; i++) begin
      grp = i / 16;
      case (grp)
        0: begin f = d ^ (b & (c ^ d)); g = i; end
        1: begin f = c ^ (d & (b ^ c)); g = (5*i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3*i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7*i) % 16; end
      endcase
      t = f + a + K[i] + m[g];
      a = d; d = c; c = b;
      b = b + rotl(t, ROT[grp*4 + i%4]);
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic restart_hash();
    chain = IV;
    fill = 0;
    nbytes = '0;
    finished = 0;
  endtask

  task automatic predict_digest(input hash_op_t op);
    logic [63:0] bits;
    int pos;
    case (op.op)
      CMD_APPEND: begin
        if (finished) begin
          expected_beats.push_back('{32'd0, 2'd0, 1'b1, 1'b1});
        end else begin
          blk[fill] = op.data;
          fill++;
          nbytes++;
          if (fill == 64) begin
            md5_compress();
            fill = 0;
          end
        end
      end
      CMD_FINISH: begin
        if (!finished) begin
          bits = nbytes << 3;
          pos = fill;
          blk[pos] = 8'h80;
          pos++;
          if (pos > 56) begin
            for (int i = pos; i < 64; i++) blk[i] = 8'h00;
            md5_compress();
            pos = 0;
          end
          for (int i = pos; i < 56; i++) blk[i] = 8'h00;
          for (int i = 0; i < 8; i++) blk[56+i] = bits[8*i +: 8];
          md5_compress();
          fill = 0;
          finished = 1;
        end
        for (int k = 0; k < 4; k++)
          expected_beats.push_back('{chain[k], 2'(k), k == 3, 1'b0});
      end
      CMD_RESTART: restart_hash();
      default: ;
    endcase
  endtask

  task automatic queue_message(input int len, input bit fin);
    for (int i = 0; i < len; i++)
      pending_ops.push_back('{CMD_APPEND, 8'($urandom_range(0, 255))});
    if (fin) pending_ops.push_back('{CMD_FINISH, 8'($urandom_range(0, 255))});
  endtask

  // Driver: one transaction at a time from pending_ops, random gap before each.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_wait <= $urandom_range(0, 10);
    end else if (in_valid && !in_accepted) begin
    end else if (in_wait > 0 || hold_sender) begin
      in_valid <= 1'b0;
      if (in_wait > 0) in_wait <= in_wait - 1;
    end else if (pending_ops.size() > 0) begin
      in_valid <= 1'b1;
      cmd <= pending_ops[0].op;
      data_byte <= pending_ops[0].data;
      in_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      void'(pending_ops.pop_front());
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    in_accepted <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) predict_digest('{cmd_t'(cmd), data_byte});
  end

  // Receiver stall and result check.
  always @(negedge clk) begin
    int w;
    if (rst) begin
      out_ready <= 1'b0;
      out_wait <= 0;
    end else if (out_accepted) begin
      w = $urandom_range(0, 10);
      if (w == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        out_wait <= w - 1;
      end
    end else if (out_wait > 0) begin
      out_ready <= 1'b0;
      out_wait <= out_wait - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    digest_beat_t exp_b;
    out_accepted <= !rst && out_valid && out_ready;
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected transaction: word %h index %0d last %b error %b",
                   digest_word, word_index, last, error);
      end else begin
        exp_b = expected_beats.pop_front();
        if (exp_b.word !== digest_word || exp_b.idx !== word_index ||
            exp_b.last !== last || exp_b.err !== error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
                     exp_b.word, exp_b.idx, exp_b.last, exp_b.err,
                     digest_word, word_index, last, error);
        end
        if (exp_b.err) errors_seen++;
        else if (exp_b.last) digests_seen++;
      end
    end
  end

  initial begin
    int len;
    int r;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    cmd = CMD_APPEND;
    data_byte = 8'h00;
    mismatches = 0;
    digests_seen = 0;
    errors_seen = 0;
    stim_done = 0;
    hold_sender = 0;
    restart_hash();
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;

    // Directed: empty message, repeated finish, append after finish, unused
    // command, restart, then lengths around the padding boundary.
    pending_ops.push_back('{CMD_FINISH, 8'h00});
    pending_ops.push_back('{CMD_FINISH, 8'hff});
    pending_ops.push_back('{CMD_APPEND, 8'hff});
    pending_ops.push_back('{CMD_UNUSED, 8'h55});
    pending_ops.push_back('{CMD_RESTART, 8'haa});
    pending_ops.push_back('{CMD_APPEND, 8'h00});
    pending_ops.push_back('{CMD_APPEND, 8'hff});
    pending_ops.push_back('{CMD_UNUSED, 8'h00});
    pending_ops.push_back('{CMD_FINISH, 8'h00});
    pending_ops.push_back('{CMD_RESTART, 8'h00});
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending_ops.size() == 0 && !in_valid);
    hold_sender = 1;
    wait (expected_beats.size() == 0);
    hold_sender = 0;

    queue_message(55, 1);
    pending_ops.push_back('{CMD_RESTART, 8'h00});
    queue_message(56, 1);
    pending_ops.push_back('{CMD_RESTART, 8'h00});
    queue_message(64, 1);
    pending_ops.push_back('{CMD_RESTART, 8'h00});

    // Random: mostly complete messages, with noise commands mixed in.
    for (int n = 0; n < 4; n++) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 130) : $urandom_range(0, 20);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 40);
        if (r == 0) pending_ops.push_back('{CMD_UNUSED, 8'($urandom_range(0, 255))});
        pending_ops.push_back('{CMD_APPEND, 8'($urandom_range(0, 255))});
      end
      if ($urandom_range(0, 5) != 0) begin
        pending_ops.push_back('{CMD_FINISH, 8'($urandom_range(0, 255))});
        repeat ($urandom_range(0, 2)) begin
          if ($urandom_range(0, 1))
            pending_ops.push_back('{CMD_FINISH, 8'($urandom_range(0, 255))});
          else
            pending_ops.push_back('{CMD_APPEND, 8'($urandom_range(0, 255))});
        end
      end
      pending_ops.push_back('{CMD_RESTART, 8'($urandom_range(0, 255))});
    end
    wait (pending_ops.size() == 0 && !in_valid);
    wait (expected_beats.size() == 0);
    repeat (200) @(posedge clk);
    stim_done = 1;
    $display("Run covered %0d digests and %0d late-append errors.",
             digests_seen, errors_seen);
    if (mismatches == 0 && expected_beats.size() == 0)
      $display("PASS md5_stream_hasher");
    else
      $display("FAIL md5_stream_hasher");
    $finish;
  end

  initial begin
    #5000000;
    if (!stim_done) begin
      $display("FAIL md5_stream_hasher");
      $finish;
    end
  end

endmodule
